@@ sv/mhrc_pkg.sv @@
// Shared types, constants and the Hamming distance function of the reuse CAM.
package mhrc_pkg;

  localparam int HeadsDef  = 8;
  localparam int RowsDef   = 256;
  localparam int CandDef   = 64;
  localparam int HashBits  = 16;
  localparam int InHeads   = 8;

  localparam logic [3:0] SupportSat = 4'd15;

  typedef enum logic [1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_MEMO      = 2'd1,
    CFG_LIMIT     = 2'd2,
    CFG_MATCH     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                valid;
    logic [HashBits-1:0] hash;
    logic [31:0]         node;
    logic [31:0]         stamp;
  } row_entry_t;

  typedef struct packed {
    logic [31:0] node;
    logic [3:0]  support;
    logic [4:0]  min_dist;
    logic [31:0] stamp;
  } cand_entry_t;

  typedef struct packed {
    logic        clear;
    logic        rd_en;
    logic [7:0]  rd_idx;
    logic        wr_en;
    logic [7:0]  wr_idx;
    cand_entry_t wr_entry;
  } cand_cmd_t;

  function automatic logic [4:0] hamming(input logic [HashBits-1:0] a,
                                         input logic [HashBits-1:0] b);
    logic [HashBits-1:0] x;
    logic [4:0]          n;
    x = a ^ b;
    n = '0;
    for (int i = 0; i < HashBits; i++) begin
      n = n + {4'd0, x[i]};
    end
    return n;
  endfunction

endpackage

@@ sv/mhrc_ifs.sv @@
// Valid/ready channel interfaces for queries and results.
interface mhrc_query_if;
  logic        valid;
  logic        ready;
  logic [31:0] query_node;
  logic [15:0] hash_head0;
  logic [15:0] hash_head1;
  logic [15:0] hash_head2;
  logic [15:0] hash_head3;
  logic [15:0] hash_head4;
  logic [15:0] hash_head5;
  logic [15:0] hash_head6;
  logic [15:0] hash_head7;
  modport source (output valid, query_node, hash_head0, hash_head1, hash_head2, hash_head3,
                  hash_head4, hash_head5, hash_head6, hash_head7, input ready);
  modport sink (input valid, query_node, hash_head0, hash_head1, hash_head2, hash_head3,
                hash_head4, hash_head5, hash_head6, hash_head7, output ready);
endinterface

interface mhrc_result_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        exact;
  logic [31:0] source_node;
  logic [3:0]  vote_count;
  logic [4:0]  best_distance;
  logic        overflowed;
  modport source (output valid, hit, exact, source_node, vote_count, best_distance,
                  overflowed, input ready);
  modport sink (input valid, hit, exact, source_node, vote_count, best_distance,
                overflowed, output ready);
endinterface

@@ sv/mhrc_row_mem.sv @@
// Row store of all heads: one write port, one registered read port.
module mhrc_row_mem import mhrc_pkg::*; #(
  parameter int Depth = HeadsDef * RowsDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  row_entry_t               wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output row_entry_t               rdata_o
);

  row_entry_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ sv/mhrc_cand_store.sv @@
// Candidate table: node tags matched in parallel, counters kept in a small memory.
module mhrc_cand_store import mhrc_pkg::*; #(
  parameter int CandMax = CandDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cand_cmd_t   cmd_i,
  input  logic [31:0] look_node_i,
  output logic        hit_o,
  output logic [7:0]  hit_idx_o,
  output cand_entry_t rd_entry_o
);

  localparam int IdxW = (CandMax > 1) ? $clog2(CandMax) : 1;

  logic [CandMax-1:0] valid_q;
  logic [31:0]        node_q [CandMax];
  cand_entry_t        mem_q  [CandMax];
  logic [CandMax-1:0] match;
  logic [IdxW-1:0]    idx;

  // Stored nodes are distinct, so at most one tag matches and an OR encode suffices.
  always_comb begin
    idx = '0;
    for (int j = 0; j < CandMax; j++) begin
      match[j] = valid_q[j] && (node_q[j] == look_node_i);
      if (match[j]) begin
        idx = idx | IdxW'(j);
      end
    end
    hit_o     = |match;
    hit_idx_o = 8'(idx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.clear) begin
      valid_q <= '0;
    end else if (cmd_i.wr_en) begin
      valid_q[cmd_i.wr_idx[IdxW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      node_q[cmd_i.wr_idx[IdxW-1:0]] <= cmd_i.wr_entry.node;
      mem_q[cmd_i.wr_idx[IdxW-1:0]]  <= cmd_i.wr_entry;
    end
    if (cmd_i.rd_en) begin
      rd_entry_o <= mem_q[cmd_i.rd_idx[IdxW-1:0]];
    end
  end

endmodule

@@ sv/multi_head_hash_reuse_cam.sv @@
// Multi-head Hamming reuse CAM: query sequencer, candidate selection and row insertion.
//
// A query transaction on query_i carries a node id and one 16-bit hash per head. The block
// walks every row of every head, one row per cycle unless a vote merges into a stored
// candidate, votes matching rows into the candidate table, picks the best candidate and
// returns one result transaction on result_o. On a miss the query is stored, one row per
// head, before the result is offered. Configuration writes on cfg_we_i/cfg_idx_i/cfg_data_i
// take effect at once and are expected only while the block is idle.
// A hit costs a scan of all HEADS*ROWS_PER_HEAD rows, a merge write for each vote into an
// existing candidate and a selection read of each candidate; the single row memory read
// port paces the scan. A miss adds per head a free slot search and a hash count scan, plus
// a rescan of the head for each row evicted by the memo depth rule. query_i.ready is high
// only between queries, so one query is processed at a time.
// After reset all HEADS*ROWS_PER_HEAD row entries are cleared, one entry per cycle, while
// query_i.ready stays low. A finished result sits in an output register; while the
// receiver stalls the next query may still be accepted, but its result waits until the
// register is free.
module multi_head_hash_reuse_cam import mhrc_pkg::*; #(
  parameter int HEADS         = HeadsDef,
  parameter int ROWS_PER_HEAD = RowsDef,
  parameter int CAND_MAX      = CandDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mhrc_query_if.sink           query_i,
  mhrc_result_if.source        result_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [8:0]           cfg_data_i
);

  localparam int NRows = HEADS * ROWS_PER_HEAD;
  localparam int AW    = $clog2(NRows);
  localparam int RW    = $clog2(ROWS_PER_HEAD);
  localparam int HW    = (HEADS > 1) ? $clog2(HEADS) : 1;
  localparam int CNW   = $clog2(CAND_MAX + 1);
  localparam int LW    = (CNW > 7) ? CNW : 7;
  localparam int RCW   = $clog2(ROWS_PER_HEAD + 1);
  localparam int MW    = (RCW > 9) ? RCW : 9;

  typedef enum logic [16:0] {
    S_CLR         = 17'h00001,
    S_IDLE        = 17'h00002,
    S_SCAN        = 17'h00004,
    S_VOTE        = 17'h00008,
    S_SEL_ISSUE   = 17'h00010,
    S_SEL         = 17'h00020,
    S_SEL_DONE    = 17'h00040,
    S_FIND_ISSUE  = 17'h00080,
    S_FIND        = 17'h00100,
    S_PLACE       = 17'h00200,
    S_CNT_ISSUE   = 17'h00400,
    S_CNT         = 17'h00800,
    S_CHK         = 17'h01000,
    S_EVICT_ISSUE = 17'h02000,
    S_EVICT       = 17'h04000,
    S_EVICT_WR    = 17'h08000,
    S_OUT         = 17'h10000
  } state_e;

  // Configuration
  logic [3:0] thr_q;
  logic [8:0] memo_q;
  logic [6:0] lim_q;
  logic [4:0] mdist_q;

  // Control
  state_e          state_q, state_d;
  logic [HW-1:0]   h_q, h_d;
  logic [RW-1:0]   r_q, r_d;
  logic [AW-1:0]   base_q, base_d;
  logic [CNW-1:0]  ccnt_q, ccnt_d;
  logic [CNW-1:0]  j_q, j_d;
  logic            ovf_q, ovf_d;
  logic            best_valid_q, best_valid_d;
  logic [31:0]     ins_cnt_q, ins_cnt_d;
  logic            slot_found_q, slot_found_d;
  logic            old_found_q, old_found_d;
  logic            vic_found_q, vic_found_d;
  logic [RCW-1:0]  row_cnt_q, row_cnt_d;
  logic            out_valid_q, out_valid_d;

  // Payload
  logic [31:0]     qnode_q, qnode_d;
  logic [15:0]     hq_q [HEADS];
  logic [15:0]     hq_d [HEADS];
  logic [7:0]      vote_idx_q, vote_idx_d;
  logic [4:0]      vote_dist_q, vote_dist_d;
  logic [31:0]     vote_time_q, vote_time_d;
  cand_entry_t     best_q, best_d;
  logic [31:0]     ts_q, ts_d;
  logic [RW-1:0]   slot_q, slot_d;
  logic [RW-1:0]   old_q, old_d;
  logic [31:0]     old_time_q, old_time_d;
  logic [RW-1:0]   vic_q, vic_d;
  logic [31:0]     vic_time_q, vic_time_d;
  logic            out_load;
  logic            out_hit_q, out_exact_q, out_ovf_q;
  logic [31:0]     out_node_q;
  logic [3:0]      out_votes_q;
  logic [4:0]      out_dist_q;

  // Memories
  logic            row_we, row_re;
  logic [AW-1:0]   row_waddr, row_raddr;
  row_entry_t      row_wdata, row_rd;
  cand_cmd_t       cmd;
  logic            cand_hit;
  logic [7:0]      cand_hit_idx;
  cand_entry_t     cand_rd;

  logic [15:0]     hash_in [InHeads];
  logic [15:0]     hv;
  logic [4:0]      row_dist;
  logic            row_match, hash_eq, last_row, last_head, do_adv, accept, better, qual;
  logic [AW-1:0]   nxt_addr;
  logic [LW-1:0]   lim_eff;
  logic [3:0]      sup_inc;

  mhrc_row_mem #(.Depth(NRows)) u_row_mem (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .re_i    (row_re),
    .raddr_i (row_raddr),
    .rdata_o (row_rd)
  );

  mhrc_cand_store #(.CandMax(CAND_MAX)) u_cand_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .look_node_i (row_rd.node),
    .hit_o       (cand_hit),
    .hit_idx_o   (cand_hit_idx),
    .rd_entry_o  (cand_rd)
  );

  assign hash_in[0] = query_i.hash_head0;
  assign hash_in[1] = query_i.hash_head1;
  assign hash_in[2] = query_i.hash_head2;
  assign hash_in[3] = query_i.hash_head3;
  assign hash_in[4] = query_i.hash_head4;
  assign hash_in[5] = query_i.hash_head5;
  assign hash_in[6] = query_i.hash_head6;
  assign hash_in[7] = query_i.hash_head7;

  assign query_i.ready = (state_q == S_IDLE);
  assign accept        = query_i.valid && query_i.ready;

  assign hv        = hq_q[h_q];
  assign row_dist  = hamming(hv, row_rd.hash);
  assign row_match = row_rd.valid && (row_dist <= mdist_q);
  assign hash_eq   = row_rd.valid && (row_rd.hash == hv);
  assign last_row  = (r_q == RW'(ROWS_PER_HEAD - 1));
  assign last_head = (h_q == HW'(HEADS - 1));
  assign nxt_addr  = last_row ? base_q + AW'(ROWS_PER_HEAD) : base_q + AW'(r_q) + AW'(1);
  assign lim_eff   = (LW'(lim_q) > LW'(CAND_MAX)) ? LW'(CAND_MAX) : LW'(lim_q);
  assign sup_inc   = (cand_rd.support < SupportSat) ? cand_rd.support + 4'd1 : cand_rd.support;

  // Ranking: support, then distance, then newest time, then lowest id.
  always_comb begin
    qual = (cand_rd.node != qnode_q) && (cand_rd.support >= thr_q);
    if (!best_valid_q) begin
      better = 1'b1;
    end else if (cand_rd.support != best_q.support) begin
      better = cand_rd.support > best_q.support;
    end else if (cand_rd.min_dist != best_q.min_dist) begin
      better = cand_rd.min_dist < best_q.min_dist;
    end else if (cand_rd.stamp != best_q.stamp) begin
      better = cand_rd.stamp > best_q.stamp;
    end else begin
      better = cand_rd.node < best_q.node;
    end
  end

  always_comb begin
    state_d      = state_q;
    h_d          = h_q;
    r_d          = r_q;
    base_d       = base_q;
    ccnt_d       = ccnt_q;
    j_d          = j_q;
    ovf_d        = ovf_q;
    best_valid_d = best_valid_q;
    ins_cnt_d    = ins_cnt_q;
    slot_found_d = slot_found_q;
    old_found_d  = old_found_q;
    vic_found_d  = vic_found_q;
    row_cnt_d    = row_cnt_q;
    out_valid_d  = out_valid_q;
    qnode_d      = qnode_q;
    for (int i = 0; i < HEADS; i++) begin
      hq_d[i] = hq_q[i];
    end
    vote_idx_d   = vote_idx_q;
    vote_dist_d  = vote_dist_q;
    vote_time_d  = vote_time_q;
    best_d       = best_q;
    ts_d         = ts_q;
    slot_d       = slot_q;
    old_d        = old_q;
    old_time_d   = old_time_q;
    vic_d        = vic_q;
    vic_time_d   = vic_time_q;
    out_load     = 1'b0;
    do_adv       = 1'b0;
    row_we       = 1'b0;
    row_waddr    = base_q + AW'(r_q);
    row_wdata    = '0;
    row_re       = 1'b0;
    row_raddr    = base_q;
    cmd          = '0;

    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLR: begin
        row_we = 1'b1;
        if (last_row && last_head) begin
          h_d     = '0;
          r_d     = '0;
          base_d  = '0;
          state_d = S_IDLE;
        end else if (last_row) begin
          h_d    = h_q + HW'(1);
          r_d    = '0;
          base_d = base_q + AW'(ROWS_PER_HEAD);
        end else begin
          r_d = r_q + RW'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          qnode_d = query_i.query_node;
          for (int i = 0; i < HEADS; i++) begin
            hq_d[i] = hash_in[i];
          end
          cmd.clear    = 1'b1;
          ccnt_d       = '0;
          ovf_d        = 1'b0;
          best_valid_d = 1'b0;
          h_d          = '0;
          r_d          = '0;
          base_d       = '0;
          row_re       = 1'b1;
          row_raddr    = '0;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (row_match && cand_hit) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_idx  = cand_hit_idx;
          vote_idx_d  = cand_hit_idx;
          vote_dist_d = row_dist;
          vote_time_d = row_rd.stamp;
          state_d     = S_VOTE;
        end else begin
          if (row_match) begin
            if (LW'(ccnt_q) >= lim_eff) begin
              ovf_d = 1'b1;
            end else begin
              cmd.wr_en             = 1'b1;
              cmd.wr_idx            = 8'(ccnt_q);
              cmd.wr_entry.node     = row_rd.node;
              cmd.wr_entry.support  = 4'd1;
              cmd.wr_entry.min_dist = row_dist;
              cmd.wr_entry.stamp    = row_rd.stamp;
              ccnt_d                = ccnt_q + CNW'(1);
            end
          end
          do_adv = 1'b1;
        end
      end
      S_VOTE: begin
        cmd.wr_en             = 1'b1;
        cmd.wr_idx            = vote_idx_q;
        cmd.wr_entry.node     = cand_rd.node;
        cmd.wr_entry.support  = sup_inc;
        cmd.wr_entry.min_dist = (vote_dist_q < cand_rd.min_dist) ? vote_dist_q :
                                                                   cand_rd.min_dist;
        cmd.wr_entry.stamp    = (vote_time_q > cand_rd.stamp) ? vote_time_q : cand_rd.stamp;
        do_adv                = 1'b1;
      end
      S_SEL_ISSUE: begin
        j_d = '0;
        if (ccnt_q == '0) begin
          state_d = S_SEL_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_idx = '0;
          state_d    = S_SEL;
        end
      end
      S_SEL: begin
        if (qual && better) begin
          best_d       = cand_rd;
          best_valid_d = 1'b1;
        end
        if (j_q + CNW'(1) == ccnt_q) begin
          state_d = S_SEL_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_idx = 8'(j_q + CNW'(1));
          j_d        = j_q + CNW'(1);
        end
      end
      S_SEL_DONE: begin
        if (best_valid_q) begin
          state_d = S_OUT;
        end else begin
          ts_d      = ins_cnt_q;
          ins_cnt_d = ins_cnt_q + 32'd1;
          h_d       = '0;
          r_d       = '0;
          base_d    = '0;
          state_d   = S_FIND_ISSUE;
        end
      end
      S_FIND_ISSUE: begin
        row_re       = 1'b1;
        row_raddr    = base_q;
        slot_found_d = 1'b0;
        old_found_d  = 1'b0;
        state_d      = S_FIND;
      end
      S_FIND: begin
        if (!row_rd.valid) begin
          if (!slot_found_q) begin
            slot_found_d = 1'b1;
            slot_d       = r_q;
          end
        end else if (!old_found_q || (row_rd.stamp < old_time_q)) begin
          old_found_d = 1'b1;
          old_d       = r_q;
          old_time_d  = row_rd.stamp;
        end
        if (last_row) begin
          state_d = S_PLACE;
        end else begin
          row_re    = 1'b1;
          row_raddr = nxt_addr;
          r_d       = r_q + RW'(1);
        end
      end
      S_PLACE: begin
        row_we          = 1'b1;
        row_waddr       = base_q + AW'(slot_found_q ? slot_q : old_q);
        row_wdata.valid = 1'b1;
        row_wdata.hash  = hv;
        row_wdata.node  = qnode_q;
        row_wdata.stamp = ts_q;
        r_d             = '0;
        state_d         = S_CNT_ISSUE;
      end
      S_CNT_ISSUE: begin
        row_re    = 1'b1;
        row_raddr = base_q;
        row_cnt_d = '0;
        state_d   = S_CNT;
      end
      S_CNT: begin
        if (hash_eq) begin
          row_cnt_d = row_cnt_q + RCW'(1);
        end
        if (last_row) begin
          r_d     = '0;
          state_d = S_CHK;
        end else begin
          row_re    = 1'b1;
          row_raddr = nxt_addr;
          r_d       = r_q + RW'(1);
        end
      end
      S_CHK: begin
        if (MW'(row_cnt_q) > MW'(memo_q)) begin
          state_d = S_EVICT_ISSUE;
        end else if (last_head) begin
          state_d = S_OUT;
        end else begin
          h_d     = h_q + HW'(1);
          r_d     = '0;
          base_d  = base_q + AW'(ROWS_PER_HEAD);
          state_d = S_FIND_ISSUE;
        end
      end
      S_EVICT_ISSUE: begin
        row_re      = 1'b1;
        row_raddr   = base_q;
        vic_found_d = 1'b0;
        state_d     = S_EVICT;
      end
      S_EVICT: begin
        if (hash_eq && (!vic_found_q || (row_rd.stamp < vic_time_q))) begin
          vic_found_d = 1'b1;
          vic_d       = r_q;
          vic_time_d  = row_rd.stamp;
        end
        if (last_row) begin
          r_d     = '0;
          state_d = S_EVICT_WR;
        end else begin
          row_re    = 1'b1;
          row_raddr = nxt_addr;
          r_d       = r_q + RW'(1);
        end
      end
      S_EVICT_WR: begin
        row_we    = 1'b1;
        row_waddr = base_q + AW'(vic_q);
        row_cnt_d = row_cnt_q - RCW'(1);
        state_d   = S_CHK;
      end
      S_OUT: begin
        if (!out_valid_q || result_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Step the scan to the next row, head-major, or hand over to selection.
    if (do_adv) begin
      if (last_row && last_head) begin
        state_d = S_SEL_ISSUE;
      end else begin
        row_re    = 1'b1;
        row_raddr = nxt_addr;
        state_d   = S_SCAN;
        if (last_row) begin
          h_d    = h_q + HW'(1);
          r_d    = '0;
          base_d = base_q + AW'(ROWS_PER_HEAD);
        end else begin
          r_d = r_q + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= 4'd2;
      memo_q  <= 9'd4;
      lim_q   <= 7'd64;
      mdist_q <= 5'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_THRESHOLD: thr_q   <= cfg_data_i[3:0];
        CFG_MEMO:      memo_q  <= cfg_data_i;
        CFG_LIMIT:     lim_q   <= cfg_data_i[6:0];
        CFG_MATCH:     mdist_q <= cfg_data_i[4:0];
        default:       thr_q   <= thr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      h_q          <= '0;
      r_q          <= '0;
      base_q       <= '0;
      ccnt_q       <= '0;
      j_q          <= '0;
      ovf_q        <= 1'b0;
      best_valid_q <= 1'b0;
      ins_cnt_q    <= '0;
      slot_found_q <= 1'b0;
      old_found_q  <= 1'b0;
      vic_found_q  <= 1'b0;
      row_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      h_q          <= h_d;
      r_q          <= r_d;
      base_q       <= base_d;
      ccnt_q       <= ccnt_d;
      j_q          <= j_d;
      ovf_q        <= ovf_d;
      best_valid_q <= best_valid_d;
      ins_cnt_q    <= ins_cnt_d;
      slot_found_q <= slot_found_d;
      old_found_q  <= old_found_d;
      vic_found_q  <= vic_found_d;
      row_cnt_q    <= row_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qnode_q     <= qnode_d;
    for (int i = 0; i < HEADS; i++) begin
      hq_q[i] <= hq_d[i];
    end
    vote_idx_q  <= vote_idx_d;
    vote_dist_q <= vote_dist_d;
    vote_time_q <= vote_time_d;
    best_q      <= best_d;
    ts_q        <= ts_d;
    slot_q      <= slot_d;
    old_q       <= old_d;
    old_time_q  <= old_time_d;
    vic_q       <= vic_d;
    vic_time_q  <= vic_time_d;
    if (out_load) begin
      out_hit_q   <= best_valid_q;
      out_exact_q <= best_valid_q && (best_q.min_dist == 5'd0);
      out_node_q  <= best_valid_q ? best_q.node : '1;
      out_votes_q <= best_valid_q ? best_q.support : 4'd0;
      out_dist_q  <= best_valid_q ? best_q.min_dist : 5'd0;
      out_ovf_q   <= ovf_q;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.hit           = out_hit_q;
  assign result_o.exact         = out_exact_q;
  assign result_o.source_node   = out_node_q;
  assign result_o.vote_count    = out_votes_q;
  assign result_o.best_distance = out_dist_q;
  assign result_o.overflowed    = out_ovf_q;

endmodule

@@ sv/mhrc_checker.sv @@
// Port-level checks of the reuse CAM, bound to the top level.
module mhrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        hit_i,
  input logic        exact_i,
  input logic [31:0] source_node_i,
  input logic [3:0]  vote_count_i,
  input logic [4:0]  best_distance_i
);

  // A miss carries the fixed miss encoding.
  a_miss_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !hit_i) |->
      (source_node_i == 32'hFFFF_FFFF && vote_count_i == 4'd0 &&
       best_distance_i == 5'd0 && !exact_i))
    else $error("miss result carries non-miss fields");

  // A hit has at least one vote, a distance of at most 16, and flags exact exactly at distance zero.
  a_hit_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && hit_i) |->
      (vote_count_i != 4'd0 && best_distance_i <= 5'd16 &&
       exact_i == (best_distance_i == 5'd0)))
    else $error("hit result fields inconsistent");

  // One query at a time: ready drops right after a query transaction.
  a_one_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("query accepted while another is in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(source_node_i)))
    else $error("stalled result changed");

endmodule

bind multi_head_hash_reuse_cam mhrc_checker u_mhrc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (query_i.valid),
  .in_ready_i      (query_i.ready),
  .out_valid_i     (result_o.valid),
  .out_ready_i     (result_o.ready),
  .hit_i           (result_o.hit),
  .exact_i         (result_o.exact),
  .source_node_i   (result_o.source_node),
  .vote_count_i    (result_o.vote_count),
  .best_distance_i (result_o.best_distance)
);
